### sv/line_rasterizer_core_defines.svh
// assertion macros shared by the line rasterizer modules
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked on clk, off during reset
`define LR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LR_ASSERT(lbl, ante, cons, msg)
`define LR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/lr_pkg.sv
// types and constants of the line rasterizer
package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int CNT_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // step direction codes per axis
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_PLUS  = 2'b01;
  localparam logic [1:0] DIR_MINUS = 2'b11;

  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } out_item_t;

  // per-line setup values derived from the endpoints
  typedef struct packed {
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    logic [1:0]            dir_x;
    logic [1:0]            dir_y;
    logic [COORD_BITS-1:0] major_span;
  } line_setup_t;

  // engine status toward the stage control
  typedef struct packed {
    logic emit;
    logic last;
  } eng_status_t;

endpackage

### sv/line_rasterizer_core.sv
// line rasterizer top level: input stage, engine and result register
//
//  channel | ports                      | accepted when
//  --------+----------------------------+--------------------------
//  input   | in_valid in_ready in_data  | in_valid && in_ready
//  result  | out_valid out_ready out_data | out_valid && out_ready
//
// one item per cycle unless the result stalls; step pixels go via the input and result registers
// the input register and the engine update set that rate
// reset clears the line state, so steps give no pixel until a load item
// a stalled result holds the engine only for items that would emit a pixel
// load items and idle steps pass through while a result waits
`include "line_rasterizer_core_defines.svh"

module line_rasterizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lr_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lr_pkg::out_item_t out_data
);

  lr_pkg::in_item_t    in_item_r;
  logic                in_valid_r;
  lr_pkg::out_item_t   out_item_r;
  logic                out_valid_r;
  lr_pkg::eng_status_t status;
  lr_pkg::out_item_t   pixel;
  logic                fire;

  lr_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_item_r),
    .fire   (fire),
    .status (status),
    .pixel  (pixel)
  );

  // held item proceeds unless it emits into a full result register that out_ready does not drain
  assign fire     = in_valid_r && (!status.emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && status.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && status.emit) begin
      out_item_r <= pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `LR_ASSERT(a_no_overwrite, fire && status.emit, !out_valid_r || out_ready, "result overwritten")
  `LR_ASSERT_NEXT(a_emit_shows, fire && status.emit, out_valid_r, "emitted pixel not presented")

endmodule

### sv/lr_setup.sv
// endpoint decode: absolute spans, step directions and major span
module lr_setup (
  input  logic [lr_pkg::COORD_BITS-1:0] x_start,
  input  logic [lr_pkg::COORD_BITS-1:0] y_start,
  input  logic [lr_pkg::COORD_BITS-1:0] x_end,
  input  logic [lr_pkg::COORD_BITS-1:0] y_end,
  output lr_pkg::line_setup_t           setup
);

  // per-axis span and direction, then the larger of the two spans
  always_comb begin
    // x axis
    if (x_end > x_start) begin
      setup.span_x = x_end - x_start;
      setup.dir_x  = lr_pkg::DIR_PLUS;
    end else if (x_end == x_start) begin
      setup.span_x = '0;
      setup.dir_x  = lr_pkg::DIR_NONE;
    end else begin
      setup.span_x = x_start - x_end;
      setup.dir_x  = lr_pkg::DIR_MINUS;
    end

    // y axis
    if (y_end > y_start) begin
      setup.span_y = y_end - y_start;
      setup.dir_y  = lr_pkg::DIR_PLUS;
    end else if (y_end == y_start) begin
      setup.span_y = '0;
      setup.dir_y  = lr_pkg::DIR_NONE;
    end else begin
      setup.span_y = y_start - y_end;
      setup.dir_y  = lr_pkg::DIR_MINUS;
    end

    // larger of the two spans
    setup.major_span = (setup.span_x > setup.span_y) ? setup.span_x : setup.span_y;
  end

endmodule

### sv/lr_engine.sv
// line state registers and the per-pixel error update
`include "line_rasterizer_core_defines.svh"

module lr_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  lr_pkg::in_item_t    item,
  input  logic                fire,
  output lr_pkg::eng_status_t status,
  output lr_pkg::out_item_t   pixel
);

  localparam int CB = lr_pkg::COORD_BITS;
  localparam int EB = lr_pkg::ERR_BITS;
  localparam int NB = lr_pkg::CNT_BITS;

  logic [CB-1:0]                cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic [CB-1:0]                span_x_r, span_y_r, major_r;
  logic [1:0]                   dir_x_r, dir_y_r;
  logic [EB-1:0]                err_x_r, err_y_r, err_x_nxt, err_y_nxt;
  logic [NB-1:0]                pixels_left_r;
  logic [lr_pkg::COLOR_BITS-1:0] held_color_r;

  lr_pkg::line_setup_t setup;
  logic [EB-1:0]       sum_x, sum_y, major_ext;
  logic                is_load, is_step, active;

  lr_setup u_setup (
    .x_start (item.x_start),
    .y_start (item.y_start),
    .x_end   (item.x_end),
    .y_end   (item.y_end),
    .setup   (setup)
  );

  assign is_load   = (item.opcode == lr_pkg::OP_LOAD);
  assign is_step   = (item.opcode == lr_pkg::OP_STEP);
  assign active    = (pixels_left_r != '0);
  assign major_ext = EB'(major_r);

  // current pixel and status
  assign status.emit       = is_step && active;
  assign status.last       = (pixels_left_r == NB'(1));
  assign pixel.pixel_x     = cur_x_r;
  assign pixel.pixel_y     = cur_y_r;
  assign pixel.pixel_color = held_color_r;
  assign pixel.last_pixel  = status.last;

  // error accumulation, x axis
  always_comb begin
    sum_x     = err_x_r + EB'(span_x_r);
    err_x_nxt = sum_x;
    cur_x_nxt = cur_x_r;
    if (sum_x > major_ext) begin
      err_x_nxt = sum_x - major_ext;
      case (dir_x_r)
        lr_pkg::DIR_PLUS:  cur_x_nxt = cur_x_r + CB'(1);
        lr_pkg::DIR_MINUS: cur_x_nxt = cur_x_r - CB'(1);
        default:           cur_x_nxt = cur_x_r;
      endcase
    end
  end

  // error accumulation, y axis
  always_comb begin
    sum_y     = err_y_r + EB'(span_y_r);
    err_y_nxt = sum_y;
    cur_y_nxt = cur_y_r;
    if (sum_y > major_ext) begin
      err_y_nxt = sum_y - major_ext;
      case (dir_y_r)
        lr_pkg::DIR_PLUS:  cur_y_nxt = cur_y_r + CB'(1);
        lr_pkg::DIR_MINUS: cur_y_nxt = cur_y_r - CB'(1);
        default:           cur_y_nxt = cur_y_r;
      endcase
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      span_x_r      <= '0;
      span_y_r      <= '0;
      dir_x_r       <= lr_pkg::DIR_NONE;
      dir_y_r       <= lr_pkg::DIR_NONE;
      major_r       <= '0;
      err_x_r       <= '0;
      err_y_r       <= '0;
      pixels_left_r <= '0;
      held_color_r  <= '0;
    end else if (fire && is_load) begin
      cur_x_r       <= item.x_start;
      cur_y_r       <= item.y_start;
      span_x_r      <= setup.span_x;
      span_y_r      <= setup.span_y;
      dir_x_r       <= setup.dir_x;
      dir_y_r       <= setup.dir_y;
      major_r       <= setup.major_span;
      err_x_r       <= '0;
      err_y_r       <= '0;
      pixels_left_r <= NB'(setup.major_span) + NB'(2);
      held_color_r  <= item.line_color;
    end else if (fire && status.emit) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      err_x_r       <= err_x_nxt;
      err_y_r       <= err_y_nxt;
      pixels_left_r <= pixels_left_r - NB'(1);
    end
  end

  `LR_ASSERT(a_err_bound, 1'b1, (err_x_r <= major_ext) && (err_y_r <= major_ext), "error above major span")
  `LR_ASSERT_NEXT(a_load_count, fire && is_load, pixels_left_r == (NB'(major_r) + NB'(2)), "bad pixel count after load")
  `LR_ASSERT_NEXT(a_idle_step, fire && is_step && !active, $stable(cur_x_r) && $stable(cur_y_r) && (pixels_left_r == '0), "idle step changed state")
  `LR_ASSERT_NEXT(a_last_ends, fire && status.emit && status.last, pixels_left_r == '0, "line did not end after last pixel")

endmodule
